[hdl/rpa_pkg.sv]
// rpa_pkg: shared types, widths and codes for the point rotation pipeline
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

    // coordinate and trig formats
    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 18;
    localparam int TRIG_FRAC  = 16;
    localparam int TRIG_ONE   = 1 << TRIG_FRAC;
    localparam int MAT_SHIFT  = 48;

    // matrix build widths
    localparam int T_W        = TRIG_W + 1;
    localparam int SQ_W       = 2 * TRIG_W;
    localparam int MAT_W      = T_W + SQ_W;
    localparam int CD_SHIFT   = MAT_SHIFT - TRIG_FRAC;
    localparam int SA_SHIFT   = MAT_SHIFT - 2 * TRIG_FRAC;

    // row product widths, matrix entry cut into a low and a high part
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SPLIT      = 27;
    localparam int MAT_HI_W   = MAT_W - SPLIT;
    localparam int PP_W       = ((MAT_HI_W > SPLIT + 1) ? MAT_HI_W : SPLIT + 1) + DIFF_W;
    localparam int SUM_W      = PP_W + 2;
    localparam int ACC_W      = SUM_W + SPLIT + 1;
    localparam int FLR_W      = ACC_W - MAT_SHIFT;
    localparam int RES_W      = ((FLR_W > COORD_W) ? FLR_W : COORD_W) + 1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS     = 3'd0,
        REG_SIN     = 3'd1,
        REG_AXIS_X  = 3'd2,
        REG_AXIS_Y  = 3'd3,
        REG_AXIS_Z  = 3'd4,
        REG_PIVOT_X = 3'd5,
        REG_PIVOT_Y = 3'd6,
        REG_PIVOT_Z = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } t_result;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_angle;
        logic signed [TRIG_W-1:0] sin_angle;
        logic signed [TRIG_W-1:0] axis_x;
        logic signed [TRIG_W-1:0] axis_y;
        logic signed [TRIG_W-1:0] axis_z;
    } t_rot_cfg;

    typedef struct packed {
        logic signed [MAT_W-1:0] e0;
        logic signed [MAT_W-1:0] e1;
        logic signed [MAT_W-1:0] e2;
    } t_mat_row;

    typedef struct packed {
        t_mat_row r0;
        t_mat_row r1;
        t_mat_row r2;
    } t_matrix;

    typedef struct packed {
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
    } t_diff;

endpackage

`default_nettype wire

[hdl/rpa_matrix.sv]
// rpa_matrix: three-stage build of the rotation matrix from the angle and axis registers
`timescale 1ns / 1ps
`default_nettype none

module rpa_matrix import rpa_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_rot_cfg i_cfg,
    output t_matrix       o_mat
);

    // stage a: axis products and one minus cosine
    logic signed [TRIG_W-1:0] r_c;
    logic signed [T_W-1:0]    r_t;
    logic signed [SQ_W-1:0]   r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [SQ_W-1:0]   r_sa_x, r_sa_y, r_sa_z;

    // stage b: scaled terms, all with MAT_SHIFT fraction bits
    logic signed [MAT_W-1:0]  r_cd;
    logic signed [MAT_W-1:0]  r_tp_xx, r_tp_yy, r_tp_zz, r_tp_xy, r_tp_xz, r_tp_yz;
    logic signed [MAT_W-1:0]  r_sx, r_sy, r_sz;

    // stage c: entries
    t_matrix r_mat;

    always_ff @(posedge i_clk) begin
        r_c    <= i_cfg.cos_angle;
        r_t    <= T_W'(TRIG_ONE) - T_W'(i_cfg.cos_angle);
        r_xx   <= SQ_W'(i_cfg.axis_x) * SQ_W'(i_cfg.axis_x);
        r_yy   <= SQ_W'(i_cfg.axis_y) * SQ_W'(i_cfg.axis_y);
        r_zz   <= SQ_W'(i_cfg.axis_z) * SQ_W'(i_cfg.axis_z);
        r_xy   <= SQ_W'(i_cfg.axis_x) * SQ_W'(i_cfg.axis_y);
        r_xz   <= SQ_W'(i_cfg.axis_x) * SQ_W'(i_cfg.axis_z);
        r_yz   <= SQ_W'(i_cfg.axis_y) * SQ_W'(i_cfg.axis_z);
        r_sa_x <= SQ_W'(i_cfg.sin_angle) * SQ_W'(i_cfg.axis_x);
        r_sa_y <= SQ_W'(i_cfg.sin_angle) * SQ_W'(i_cfg.axis_y);
        r_sa_z <= SQ_W'(i_cfg.sin_angle) * SQ_W'(i_cfg.axis_z);
    end

    always_ff @(posedge i_clk) begin
        r_cd    <= MAT_W'(r_c) <<< CD_SHIFT;
        r_tp_xx <= MAT_W'(r_t) * MAT_W'(r_xx);
        r_tp_yy <= MAT_W'(r_t) * MAT_W'(r_yy);
        r_tp_zz <= MAT_W'(r_t) * MAT_W'(r_zz);
        r_tp_xy <= MAT_W'(r_t) * MAT_W'(r_xy);
        r_tp_xz <= MAT_W'(r_t) * MAT_W'(r_xz);
        r_tp_yz <= MAT_W'(r_t) * MAT_W'(r_yz);
        r_sx    <= MAT_W'(r_sa_x) <<< SA_SHIFT;
        r_sy    <= MAT_W'(r_sa_y) <<< SA_SHIFT;
        r_sz    <= MAT_W'(r_sa_z) <<< SA_SHIFT;
    end

    // c*I + (1-c)*a*a^T + s*[a]x
    always_ff @(posedge i_clk) begin
        r_mat.r0.e0 <= r_cd + r_tp_xx;
        r_mat.r0.e1 <= r_tp_xy - r_sz;
        r_mat.r0.e2 <= r_tp_xz + r_sy;
        r_mat.r1.e0 <= r_tp_xy + r_sz;
        r_mat.r1.e1 <= r_cd + r_tp_yy;
        r_mat.r1.e2 <= r_tp_yz - r_sx;
        r_mat.r2.e0 <= r_tp_xz - r_sy;
        r_mat.r2.e1 <= r_tp_yz + r_sx;
        r_mat.r2.e2 <= r_cd + r_tp_zz;
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

[hdl/rpa_row.sv]
// rpa_row: one output coordinate, dot product of a matrix row with the offset point
`timescale 1ns / 1ps
`default_nettype none

module rpa_row import rpa_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_mat_row                  i_row,
    input  wire t_diff                     i_diff,
    input  wire logic signed [COORD_W-1:0] i_pivot,
    output logic signed [COORD_W-1:0]      o_coord
);

    logic signed [MAT_W-1:0]  w_ent   [3];
    logic signed [DIFF_W-1:0] w_dv    [3];
    logic signed [PP_W-1:0]   w_lo_op [3];
    logic signed [PP_W-1:0]   w_hi_op [3];
    logic signed [PP_W-1:0]   w_d_op  [3];

    logic signed [PP_W-1:0]   r_pl [3];
    logic signed [PP_W-1:0]   r_ph [3];
    logic signed [SUM_W-1:0]  r_sum_lo, r_sum_hi;
    logic signed [ACC_W-1:0]  r_total;
    logic signed [COORD_W-1:0] r_out;

    logic signed [FLR_W-1:0]   w_flr;
    logic signed [RES_W-1:0]   w_res;
    logic signed [COORD_W-1:0] n_out;

    assign w_ent[0] = i_row.e0;
    assign w_ent[1] = i_row.e1;
    assign w_ent[2] = i_row.e2;
    assign w_dv[0]  = i_diff.d0;
    assign w_dv[1]  = i_diff.d1;
    assign w_dv[2]  = i_diff.d2;

    // low part unsigned, high part carries the sign
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_lo_op[j] = PP_W'($signed({1'b0, w_ent[j][SPLIT-1:0]}));
            w_hi_op[j] = PP_W'($signed(w_ent[j][MAT_W-1:SPLIT]));
            w_d_op[j]  = PP_W'(w_dv[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_pl[j] <= w_lo_op[j] * w_d_op[j];
            r_ph[j] <= w_hi_op[j] * w_d_op[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_lo <= SUM_W'(r_pl[0]) + SUM_W'(r_pl[1]) + SUM_W'(r_pl[2]);
        r_sum_hi <= SUM_W'(r_ph[0]) + SUM_W'(r_ph[1]) + SUM_W'(r_ph[2]);
    end

    always_ff @(posedge i_clk) begin
        r_total <= (ACC_W'(r_sum_hi) <<< SPLIT) + ACC_W'(r_sum_lo);
    end

    // arithmetic shift gives the floor, then pivot back and clamp
    always_comb begin
        w_flr = FLR_W'(r_total >>> MAT_SHIFT);
        w_res = RES_W'(w_flr) + RES_W'(i_pivot);
        if (w_res > RES_W'(COORD_MAX)) begin
            n_out = COORD_MAX;
        end else if (w_res < RES_W'(COORD_MIN)) begin
            n_out = COORD_MIN;
        end else begin
            n_out = $signed(w_res[COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_coord = r_out;

endmodule

`default_nettype wire

[hdl/rotate_point_about_axis.sv]
// rotate_point_about_axis: top level, config registers, offset stage and output pipeline
`timescale 1ns / 1ps
`default_nettype none

// Rotates each point about a unit axis through a pivot by the angle whose cosine and
// sine sit in the config registers. One point is accepted every cycle; o_busy is high
// only while reset is held. Each result appears on o_result in the cycle o_done is
// high, in start order, and must be taken in that cycle. The register stages of the
// pipeline are pivot subtraction, the offset delays that wait for the matrix build,
// partial products, row sums, the wide combine, and the rounding and saturation
// stage. Config writes are always ready and apply to points started on the following
// cycle or later; write them only while no point is in flight.

module rotate_point_about_axis import rpa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_point                i_point,
    output logic                       o_busy,
    output logic                       o_done,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LATENCY = 7;

    t_rot_cfg                  r_cfg;
    logic signed [COORD_W-1:0] r_pivot_x, r_pivot_y, r_pivot_z;
    logic [LATENCY-1:0]        r_vld;
    t_diff                     n_diff;
    t_diff                     r_d1, r_d2, r_d3;
    t_matrix                   w_mat;
    logic                      w_accept;
    logic                      w_cfg_wr;
    logic signed [TRIG_W-1:0]  w_trig_word;

    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start & ~o_busy;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_trig_word = $signed(i_cfg_data[TRIG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle <= TRIG_W'(TRIG_ONE);
            r_cfg.sin_angle <= '0;
            r_cfg.axis_x    <= '0;
            r_cfg.axis_y    <= '0;
            r_cfg.axis_z    <= TRIG_W'(TRIG_ONE);
            r_pivot_x       <= '0;
            r_pivot_y       <= '0;
            r_pivot_z       <= '0;
        end else if (w_cfg_wr) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_COS:     r_cfg.cos_angle <= w_trig_word;
                REG_SIN:     r_cfg.sin_angle <= w_trig_word;
                REG_AXIS_X:  r_cfg.axis_x    <= w_trig_word;
                REG_AXIS_Y:  r_cfg.axis_y    <= w_trig_word;
                REG_AXIS_Z:  r_cfg.axis_z    <= w_trig_word;
                REG_PIVOT_X: r_pivot_x       <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_PIVOT_Y: r_pivot_y       <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_PIVOT_Z: r_pivot_z       <= $signed(i_cfg_data[COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // valid bits march alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    always_comb begin
        n_diff.d0 = DIFF_W'(i_point.point_x) - DIFF_W'(r_pivot_x);
        n_diff.d1 = DIFF_W'(i_point.point_y) - DIFF_W'(r_pivot_y);
        n_diff.d2 = DIFF_W'(i_point.point_z) - DIFF_W'(r_pivot_z);
    end

    // offset passes through r_d2 and r_d3 while the matrix build catches up
    always_ff @(posedge i_clk) begin
        r_d1 <= n_diff;
        r_d2 <= r_d1;
        r_d3 <= r_d2;
    end

    rpa_matrix u_matrix (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .o_mat (w_mat)
    );

    rpa_row u_row_x (
        .i_clk   (i_clk),
        .i_row   (w_mat.r0),
        .i_diff  (r_d3),
        .i_pivot (r_pivot_x),
        .o_coord (o_result.out_x)
    );

    rpa_row u_row_y (
        .i_clk   (i_clk),
        .i_row   (w_mat.r1),
        .i_diff  (r_d3),
        .i_pivot (r_pivot_y),
        .o_coord (o_result.out_y)
    );

    rpa_row u_row_z (
        .i_clk   (i_clk),
        .i_row   (w_mat.r2),
        .i_diff  (r_d3),
        .i_pivot (r_pivot_z),
        .o_coord (o_result.out_z)
    );

    assign o_done = r_vld[LATENCY-1];

    // every accepted word comes out of the pipeline with o_done
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("accepted word did not complete after pipeline latency");

    // no result without a matching accept
    a_done_has_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching accept");

endmodule

`default_nettype wire

[tb/sv/rpa_checker.sv]
// rpa_checker: predicts each rotated point and compares it with the block's result words
`timescale 1ns / 1ps

module rpa_checker import rpa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_point                i_point,
    input  wire logic                  i_busy,
    input  wire logic                  i_done,
    input  wire t_result               i_result,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_in_flight
);

    logic signed [TRIG_W-1:0]  cos_r, sin_r, ax_r, ay_r, az_r;
    logic signed [COORD_W-1:0] pivot_r [3];
    t_result                   rotated_q [$];
    int                        err_cnt;

    // exact matrix at 48 fraction bits, one floor per row, then pivot and clamp
    function automatic t_result rotate(input t_point p);
        logic signed [127:0]       c, s, ax, ay, az, t, sx, sy, sz, cd, acc;
        logic signed [127:0]       m [3][3];
        logic signed [127:0]       d [3];
        logic signed [COORD_W-1:0] row_out [3];
        c  = cos_r;
        s  = sin_r;
        ax = ax_r;
        ay = ay_r;
        az = az_r;
        t  = TRIG_ONE - c;
        cd = c <<< CD_SHIFT;
        sx = (ax * s) <<< SA_SHIFT;
        sy = (ay * s) <<< SA_SHIFT;
        sz = (az * s) <<< SA_SHIFT;
        m[0][0] = cd + t * ax * ax;
        m[0][1] = t * ax * ay - sz;
        m[0][2] = t * ax * az + sy;
        m[1][0] = t * ax * ay + sz;
        m[1][1] = cd + t * ay * ay;
        m[1][2] = t * ay * az - sx;
        m[2][0] = t * ax * az - sy;
        m[2][1] = t * ay * az + sx;
        m[2][2] = cd + t * az * az;
        d[0] = $signed(p.point_x);
        d[1] = $signed(p.point_y);
        d[2] = $signed(p.point_z);
        for (int j = 0; j < 3; j++)
            d[j] = d[j] - pivot_r[j];
        for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * d[0] + m[i][1] * d[1] + m[i][2] * d[2];
            acc = (acc >>> MAT_SHIFT) + pivot_r[i];
            if (acc > COORD_MAX)
                row_out[i] = COORD_MAX;
            else if (acc < COORD_MIN)
                row_out[i] = COORD_MIN;
            else
                row_out[i] = acc[COORD_W-1:0];
        end
        return '{out_x: row_out[0], out_y: row_out[1], out_z: row_out[2]};
    endfunction

    task automatic log_error(input string what, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] mismatch on %0s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            cos_r   = TRIG_ONE;
            sin_r   = '0;
            ax_r    = '0;
            ay_r    = '0;
            az_r    = TRIG_ONE;
            pivot_r = '{default: '0};
            rotated_q.delete();
        end else begin
            // a point started here still sees the old settings
            if (i_start === 1'b1 && i_busy === 1'b0)
                rotated_q.push_back(rotate(i_point));
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_COS:     cos_r      = i_cfg_data[TRIG_W-1:0];
                    REG_SIN:     sin_r      = i_cfg_data[TRIG_W-1:0];
                    REG_AXIS_X:  ax_r       = i_cfg_data[TRIG_W-1:0];
                    REG_AXIS_Y:  ay_r       = i_cfg_data[TRIG_W-1:0];
                    REG_AXIS_Z:  az_r       = i_cfg_data[TRIG_W-1:0];
                    REG_PIVOT_X: pivot_r[0] = i_cfg_data;
                    REG_PIVOT_Y: pivot_r[1] = i_cfg_data;
                    REG_PIVOT_Z: pivot_r[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done === 1'b1) begin
                if (rotated_q.size() == 0) begin
                    log_error("unexpected word", 'x, i_result.out_x);
                end else begin
                    want = rotated_q.pop_front();
                    if (i_result.out_x !== want.out_x)
                        log_error("out_x", want.out_x, i_result.out_x);
                    if (i_result.out_y !== want.out_y)
                        log_error("out_y", want.out_y, i_result.out_y);
                    if (i_result.out_z !== want.out_z)
                        log_error("out_z", want.out_z, i_result.out_z);
                end
            end
        end
        o_errors    <= err_cnt;
        o_in_flight <= rotated_q.size();
    end

endmodule

[tb/sv/tb_rotate_point_about_axis.sv]
// tb_rotate_point_about_axis: clock, reset, point and config stimulus, and the verdict
`timescale 1ns / 1ps

module tb_rotate_point_about_axis;
    import rpa_pkg::*;

    localparam int LATENCY      = 7;
    localparam int MAX_CYCLES   = 200000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TRIG_MAX     = (1 << (TRIG_W - 1)) - 1;
    localparam int TRIG_MIN     = -(1 << (TRIG_W - 1));

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    t_point                i_point;
    logic                  o_busy;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    in_flight;
    int                    cycles;

    rotate_point_about_axis dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_point     (i_point),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rpa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_point     (i_point),
        .i_busy      (o_busy),
        .i_done      (o_done),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_in_flight (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (cycles = 0; cycles < MAX_CYCLES; cycles++)
            @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // trig word with junk above bit 17, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] trig_word(input int v);
        logic [CFG_DATA_W-1:0] w;
        w = $urandom;
        w[TRIG_W-1:0] = v[TRIG_W-1:0];
        return w;
    endfunction

    function automatic int rand_trig();
        case ($urandom_range(0, 7))
            0:       return TRIG_ONE;
            1:       return -TRIG_ONE;
            2:       return 0;
            3:       return TRIG_MAX;
            4:       return TRIG_MIN;
            default: return int'($urandom_range(0, 2 * TRIG_ONE)) - TRIG_ONE;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3, 4: return $urandom;
            default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        endcase
    endfunction

    task automatic send(input logic [COORD_W-1:0] x, y, z);
        @(negedge i_clk);
        i_start = 1'b1;
        i_point = '{point_x: x, point_y: y, point_z: z};
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // drop start and let the pipeline empty out
    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (in_flight != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic set_rotation(input logic [CFG_DATA_W-1:0] c, s, ax, ay, az, px, py, pz);
        t_cfg_index            order [8];
        logic [CFG_DATA_W-1:0] vals [8];
        order = '{REG_COS, REG_SIN, REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
                  REG_PIVOT_X, REG_PIVOT_Y, REG_PIVOT_Z};
        vals  = '{c, s, ax, ay, az, px, py, pz};
        settle();
        for (int k = 0; k < 8; k++) begin
            @(negedge i_clk);
            i_cfg_valid = 1'b1;
            i_cfg_index = order[k];
            i_cfg_data  = vals[k];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1)
                @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        int burst_left;
        int gap;
        int phase_len;
        int sent;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_point     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_COS;
        i_cfg_data  = '0;
        burst_left  = 0;
        sent        = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // settings after reset are the identity
        send(0, 0, 0);
        send(COORD_MAX, COORD_MIN, COORD_MAX);
        send(COORD_MIN, COORD_MAX, COORD_MIN);
        send(1, -1, TRIG_ONE);
        send(32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF);

        // quarter turn about z through an offset pivot
        set_rotation(trig_word(0), trig_word(TRIG_ONE), trig_word(0), trig_word(0),
                     trig_word(TRIG_ONE), 32'h0003_0000, 32'hFFFE_0000, 32'd12345);
        send(32'h0003_0000, 32'hFFFE_0000, 32'd12345);
        send(32'h0004_0000, 0, 0);
        send(COORD_MAX, COORD_MAX, COORD_MAX);
        send(COORD_MIN, 0, 7);

        // every trig register at a range end, x and y pivots at the corners: clamps both ways
        set_rotation(trig_word(TRIG_MIN), trig_word(TRIG_MAX), trig_word(TRIG_MAX),
                     trig_word(TRIG_MIN), trig_word(TRIG_MAX), COORD_MIN, COORD_MAX, 0);
        send(COORD_MAX, COORD_MIN, COORD_MAX);
        send(COORD_MIN, COORD_MAX, COORD_MIN);
        send(0, 0, 0);
        send(1, 1, 1);

        // cos and sin not a pair, axis not unit length
        set_rotation(trig_word(30000), trig_word(-50000), trig_word(TRIG_ONE),
                     trig_word(TRIG_ONE), trig_word(TRIG_ONE), -1, -1, -1);
        send(-1, -1, -1);
        send(123456, -654321, 42);
        send(COORD_MIN, COORD_MIN, COORD_MIN);

        // half turn about -x with the pivot at the top corner
        set_rotation(trig_word(-TRIG_ONE), trig_word(0), trig_word(-TRIG_ONE),
                     trig_word(0), trig_word(0), COORD_MAX, COORD_MAX, COORD_MAX);
        send(COORD_MAX, COORD_MAX, COORD_MAX);
        send(0, 0, 0);
        send(COORD_MIN, 1, -1);

        // random settings per phase, points in bursts with random gaps
        while (sent < RANDOM_ITEMS) begin
            set_rotation(trig_word(rand_trig()), trig_word(rand_trig()),
                         trig_word(rand_trig()), trig_word(rand_trig()),
                         trig_word(rand_trig()), rand_coord(), rand_coord(), rand_coord());
            phase_len = $urandom_range(60, 200);
            for (int n = 0; n < phase_len; n++) begin
                send(rand_coord(), rand_coord(), rand_coord());
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    repeat (gap) begin
                        @(negedge i_clk);
                        i_start = 1'b0;
                    end
                end else begin
                    burst_left--;
                end
            end
            sent += phase_len;
        end
        settle();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
